// File: rtl/core/gplr_pkg.sv
`timescale 1ns / 1ps
package gplr_pkg;

  localparam int CFG_W      = 32;
  localparam int WORLD_W    = 17;
  localparam int END_ROW_W  = 12;
  localparam int READ_W     = 10;
  localparam int DX_W       = 10;
  localparam int STAMP_HALF = 3;
  localparam int STAMP_LAST = 5;
  localparam int GRID_STEP  = 40;
  localparam int AXIS_HALF  = 2;
  localparam int TIP_COLS   = 10;
  localparam int WORLD_SPAN = 640;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_POINT  = 2'd1;
  localparam logic [1:0] REQ_VECTOR = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] IDX_BACKGROUND = 2'd0;
  localparam logic [1:0] IDX_AXIS       = 2'd1;
  localparam logic [1:0] IDX_POINT      = 2'd2;
  localparam logic [1:0] IDX_TIP        = 2'd3;

  localparam logic [1:0] CFG_BACKGROUND = 2'd0;
  localparam logic [1:0] CFG_AXIS       = 2'd1;
  localparam logic [1:0] CFG_POINT      = 2'd2;
  localparam logic [1:0] CFG_TIP        = 2'd3;

  localparam logic [CFG_W-1:0] RST_BACKGROUND = 32'd4281540382;
  localparam logic [CFG_W-1:0] RST_AXIS       = 32'd4294954086;
  localparam logic [CFG_W-1:0] RST_POINT      = 32'd4294901502;
  localparam logic [CFG_W-1:0] RST_TIP        = 32'd4278190335;

  typedef struct packed {
    logic load;
    logic map;
    logic vec_init;
    logic vec_mul;
    logic row_direct;
    logic div_start;
    logic div_step;
    logic div_fin;
    logic stamp_pt;
    logic stamp_vec;
    logic stamp_step;
    logic col_next;
    logic clr_step;
    logic rd_issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       leftward;
    logic       dx_zero;
    logic       div_last;
    logic       stamp_last;
    logic       col_last;
    logic       clr_last;
  } ctrl_stat_t;

endpackage

// File: rtl/core/gplr_ram.sv
`timescale 1ns / 1ps
module gplr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 640000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/gplr_datapath.sv
`timescale 1ns / 1ps
module gplr_datapath #(
  parameter int CANVAS_WIDTH  = 800,
  parameter int CANVAS_HEIGHT = 800
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gplr_pkg::ctrl_cmd_t                  cmd,
  output gplr_pkg::ctrl_stat_t                 stat,
  input  logic [1:0]                           req_type,
  input  logic signed [gplr_pkg::WORLD_W-1:0]  world_x,
  input  logic signed [gplr_pkg::WORLD_W-1:0]  world_y,
  input  logic [gplr_pkg::READ_W-1:0]          read_col,
  input  logic [gplr_pkg::READ_W-1:0]          read_row,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [gplr_pkg::CFG_W-1:0]           cfg_data,
  output logic                                 done,
  output logic [gplr_pkg::CFG_W-1:0]           pixel_color,
  output logic signed [gplr_pkg::END_ROW_W-1:0] end_row
);

  localparam int X0      = CANVAS_WIDTH / 2;
  localparam int Y0      = CANVAS_HEIGHT / 2;
  localparam int MAXD    = (CANVAS_WIDTH > CANVAS_HEIGHT) ? CANVAS_WIDTH : CANVAS_HEIGHT;
  localparam int DEPTH   = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COLB    = $clog2(CANVAS_WIDTH);
  localparam int ROWB    = $clog2(CANVAS_HEIGHT);
  localparam int COORD_W = $clog2(MAXD / 2 + gplr_pkg::WORLD_SPAN + 1) + 1;
  localparam int MAP_W   = $clog2(MAXD / 2 * 4096 + 40 * 65536 + 1) + 1;
  localparam int NUM_W   = $clog2((MAXD / 2) * gplr_pkg::WORLD_SPAN
                                  + gplr_pkg::WORLD_SPAN * gplr_pkg::WORLD_SPAN + 1) + 1;
  localparam int DIVC_W  = $clog2(NUM_W);
  localparam int DX_W    = gplr_pkg::DX_W;

  // latched request
  logic [1:0]                      req;
  logic signed [gplr_pkg::WORLD_W-1:0] wx, wy;
  logic [gplr_pkg::READ_W-1:0]     rc, rr;
  logic [gplr_pkg::CFG_W-1:0]      palette [4];

  // mapped target and vector state
  logic signed [COORD_W-1:0] x1, y1, col, row;
  logic [DX_W-1:0]           dx;
  logic signed [NUM_W-1:0]   dy, num;

  // divider
  logic [NUM_W-1:0]  dq;
  logic [DX_W-1:0]   rem;
  logic [DIVC_W-1:0] dcnt;
  logic              dneg;

  // stamp
  logic signed [COORD_W-1:0] scx, scy;
  logic [1:0]                sidx;
  logic [2:0]                sx, sy;

  // clear sweep
  logic [COLB-1:0]   cx;
  logic [ROWB-1:0]   cy;
  logic [5:0]        xm, ym;
  logic [ADDR_W-1:0] caddr;

  logic              rd_ok;
  logic [1:0]        rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette[gplr_pkg::CFG_BACKGROUND] <= gplr_pkg::RST_BACKGROUND;
      palette[gplr_pkg::CFG_AXIS]       <= gplr_pkg::RST_AXIS;
      palette[gplr_pkg::CFG_POINT]      <= gplr_pkg::RST_POINT;
      palette[gplr_pkg::CFG_TIP]        <= gplr_pkg::RST_TIP;
    end else if (cfg_we) begin
      palette[cfg_index] <= cfg_data;
    end
  end

  // world to pixel mapping, truncating toward zero
  logic signed [MAP_W-1:0] wx_ext, wy_ext, mx, my, qx, qy;
  always_comb begin
    wx_ext = {{(MAP_W-gplr_pkg::WORLD_W){wx[gplr_pkg::WORLD_W-1]}}, wx};
    wy_ext = {{(MAP_W-gplr_pkg::WORLD_W){wy[gplr_pkg::WORLD_W-1]}}, wy};
    mx = MAP_W'(X0 * 4096) + (wx_ext <<< 5) + (wx_ext <<< 3);
    my = MAP_W'(Y0 * 4096) - (wy_ext <<< 5) - (wy_ext <<< 3);
    qx = mx >>> 12;
    qy = my >>> 12;
    if (mx[MAP_W-1] && (mx[11:0] != 12'd0)) qx = qx + MAP_W'(1);
    if (my[MAP_W-1] && (my[11:0] != 12'd0)) qy = qy + MAP_W'(1);
  end

  // stamp pixel and its bounds
  logic signed [COORD_W:0] px, py;
  logic                    pvalid;
  always_comb begin
    px = {scx[COORD_W-1], scx} - (COORD_W+1)'(gplr_pkg::STAMP_HALF)
         + {{(COORD_W-2){1'b0}}, sx};
    py = {scy[COORD_W-1], scy} - (COORD_W+1)'(gplr_pkg::STAMP_HALF)
         + {{(COORD_W-2){1'b0}}, sy};
    pvalid = !px[COORD_W] && !py[COORD_W]
             && (px < $signed((COORD_W+1)'(CANVAS_WIDTH)))
             && (py < $signed((COORD_W+1)'(CANVAS_HEIGHT)));
  end

  // one shared row*width multiplier for stamp writes and pixel reads
  logic [ROWB+gplr_pkg::READ_W-1:0] rr_ext;
  logic [COLB+gplr_pkg::READ_W-1:0] rc_ext;
  logic [ROWB-1:0]   sel_row;
  logic [COLB-1:0]   sel_col;
  logic [ADDR_W-1:0] paddr;
  always_comb begin
    rr_ext = {{ROWB{1'b0}}, rr};
    rc_ext = {{COLB{1'b0}}, rc};
    if (cmd.rd_issue) begin
      sel_row = rr_ext[ROWB-1:0];
      sel_col = rc_ext[COLB-1:0];
    end else begin
      sel_row = py[ROWB-1:0];
      sel_col = px[COLB-1:0];
    end
    paddr = ADDR_W'(sel_row) * ADDR_W'(CANVAS_WIDTH) + ADDR_W'(sel_col);
  end

  logic axis;
  always_comb begin
    axis = (xm == 6'd0) || (ym == 6'd0)
           || (({1'b0, cy} >= (ROWB+1)'(Y0 - gplr_pkg::AXIS_HALF))
               && ({1'b0, cy} <= (ROWB+1)'(Y0 + gplr_pkg::AXIS_HALF)))
           || (({1'b0, cx} >= (COLB+1)'(X0 - gplr_pkg::AXIS_HALF))
               && ({1'b0, cx} <= (COLB+1)'(X0 + gplr_pkg::AXIS_HALF)));
  end

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [1:0]        wdata;
  always_comb begin
    we    = cmd.clr_step || (cmd.stamp_step && pvalid);
    waddr = cmd.clr_step ? caddr : paddr;
    wdata = cmd.clr_step ? (axis ? gplr_pkg::IDX_AXIS : gplr_pkg::IDX_BACKGROUND) : sidx;
  end

  gplr_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_issue),
    .raddr (paddr),
    .rdata (rdata)
  );

  logic [DX_W:0]            trial;
  logic [NUM_W-1:0]         qs;
  logic signed [COORD_W:0]  tip_gap;
  always_comb begin
    trial   = {rem, dq[NUM_W-1]};
    qs      = dneg ? (~dq + NUM_W'(1)) : dq;
    tip_gap = {x1[COORD_W-1], x1} - {col[COORD_W-1], col};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= req_type;
      wx    <= world_x;
      wy    <= world_y;
      rc    <= read_col;
      rr    <= read_row;
      cx    <= '0;
      cy    <= '0;
      xm    <= '0;
      ym    <= '0;
      caddr <= '0;
    end
    if (cmd.map) begin
      x1 <= qx[COORD_W-1:0];
      y1 <= qy[COORD_W-1:0];
    end
    if (cmd.vec_init) begin
      dx <= DX_W'(x1 - COORD_W'(X0));
      dy <= NUM_W'(y1 - COORD_W'(Y0));
    end
    if (cmd.vec_mul) begin
      num <= $signed(NUM_W'(NUM_W'(Y0) * {{(NUM_W-DX_W){1'b0}}, dx}));
      col <= COORD_W'(X0);
    end
    if (cmd.col_next) begin
      num <= num + dy;
      col <= col + COORD_W'(1);
    end
    if (cmd.row_direct) row <= COORD_W'(Y0);
    if (cmd.div_start) begin
      dneg <= num[NUM_W-1];
      dq   <= num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
      rem  <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, dx}) begin
        rem <= DX_W'(trial - {1'b0, dx});
        dq  <= {dq[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DX_W-1:0];
        dq  <= {dq[NUM_W-2:0], 1'b0};
      end
      dcnt <= dcnt + DIVC_W'(1);
    end
    if (cmd.div_fin) row <= qs[COORD_W-1:0];
    if (cmd.stamp_pt) begin
      scx  <= x1;
      scy  <= y1;
      sidx <= gplr_pkg::IDX_POINT;
      sx   <= '0;
      sy   <= '0;
    end
    if (cmd.stamp_vec) begin
      scx  <= col;
      scy  <= row;
      sidx <= (tip_gap <= (COORD_W+1)'(gplr_pkg::TIP_COLS)) ? gplr_pkg::IDX_TIP
                                                              : gplr_pkg::IDX_POINT;
      sx   <= '0;
      sy   <= '0;
    end
    if (cmd.stamp_step) begin
      if (sx == 3'(gplr_pkg::STAMP_LAST)) begin
        sx <= '0;
        sy <= sy + 3'd1;
      end else begin
        sx <= sx + 3'd1;
      end
    end
    if (cmd.clr_step) begin
      caddr <= caddr + ADDR_W'(1);
      if (cx == COLB'(CANVAS_WIDTH - 1)) begin
        cx <= '0;
        xm <= '0;
        cy <= cy + ROWB'(1);
        ym <= (ym == 6'(gplr_pkg::GRID_STEP - 1)) ? 6'd0 : ym + 6'd1;
      end else begin
        cx <= cx + COLB'(1);
        xm <= (xm == 6'(gplr_pkg::GRID_STEP - 1)) ? 6'd0 : xm + 6'd1;
      end
    end
    if (cmd.rd_issue) begin
      rd_ok <= (rc_ext < (COLB+gplr_pkg::READ_W)'(CANVAS_WIDTH))
               && (rr_ext < (ROWB+gplr_pkg::READ_W)'(CANVAS_HEIGHT));
    end
  end

  logic [COORD_W+gplr_pkg::END_ROW_W-1:0] y1_ext;
  always_comb y1_ext = {{gplr_pkg::END_ROW_W{y1[COORD_W-1]}}, y1};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      pixel_color <= ((req == gplr_pkg::REQ_READ) && rd_ok) ? palette[rdata] : '0;
      end_row     <= (req == gplr_pkg::REQ_VECTOR) ? y1_ext[gplr_pkg::END_ROW_W-1:0] : '0;
    end
  end

  always_comb begin
    stat.req_type   = req;
    stat.leftward   = x1 < $signed(COORD_W'(X0));
    stat.dx_zero    = (dx == '0);
    stat.div_last   = (dcnt == DIVC_W'(NUM_W - 1));
    stat.stamp_last = (sx == 3'(gplr_pkg::STAMP_LAST)) && (sy == 3'(gplr_pkg::STAMP_LAST));
    stat.col_last   = (col == x1);
    stat.clr_last   = (cx == COLB'(CANVAS_WIDTH - 1)) && (cy == ROWB'(CANVAS_HEIGHT - 1));
  end

endmodule

// File: rtl/core/gplr_ctrl.sv
`timescale 1ns / 1ps
module gplr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           req_type,
  output logic                 busy,
  output gplr_pkg::ctrl_cmd_t  cmd,
  input  gplr_pkg::ctrl_stat_t stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAP    = 4'd1;
  localparam logic [3:0] S_PT     = 4'd2;
  localparam logic [3:0] S_VINIT  = 4'd3;
  localparam logic [3:0] S_VMUL   = 4'd4;
  localparam logic [3:0] S_VCOL   = 4'd5;
  localparam logic [3:0] S_VDIV   = 4'd6;
  localparam logic [3:0] S_VFIN   = 4'd7;
  localparam logic [3:0] S_VSTART = 4'd8;
  localparam logic [3:0] S_STAMP  = 4'd9;
  localparam logic [3:0] S_VNEXT  = 4'd10;
  localparam logic [3:0] S_CLR    = 4'd11;
  localparam logic [3:0] S_RD     = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (req_type)
            gplr_pkg::REQ_CLEAR: state_next = S_CLR;
            gplr_pkg::REQ_READ:  state_next = S_RD;
            default:             state_next = S_MAP;
          endcase
        end
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = (stat.req_type == gplr_pkg::REQ_POINT) ? S_PT : S_VINIT;
      end
      S_PT: begin
        cmd.stamp_pt = 1'b1;
        state_next   = S_STAMP;
      end
      S_VINIT: begin
        // leftward target: draw nothing, still report the end row
        cmd.vec_init = 1'b1;
        state_next   = stat.leftward ? S_DONE : S_VMUL;
      end
      S_VMUL: begin
        cmd.vec_mul = 1'b1;
        state_next  = S_VCOL;
      end
      S_VCOL: begin
        if (stat.dx_zero) begin
          cmd.row_direct = 1'b1;
          state_next     = S_VSTART;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_VDIV;
        end
      end
      S_VDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_VFIN;
      end
      S_VFIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_VSTART;
      end
      S_VSTART: begin
        cmd.stamp_vec = 1'b1;
        state_next    = S_STAMP;
      end
      S_STAMP: begin
        cmd.stamp_step = 1'b1;
        if (stat.stamp_last) begin
          state_next = (stat.req_type == gplr_pkg::REQ_VECTOR) ? S_VNEXT : S_DONE;
        end
      end
      S_VNEXT: begin
        if (stat.col_last) begin
          state_next = S_DONE;
        end else begin
          cmd.col_next = 1'b1;
          state_next   = S_VCOL;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_DONE;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/core/grid_plot_line_rasterizer_top.sv
// Per request: clear sweeps each pixel, point stamps its target, read fetches one pixel;
// vector: row divide and stamp per column; vertical skips divide, leftward draws nothing.
// One request at a time through the single framebuffer write port; busy is high meanwhile.
// Each result is shown for one cycle with done high; the receiver cannot stall.
// Synchronous reset idles the controller and restores the palette; the framebuffer
// holds no defined contents until the first clear request.
`timescale 1ns / 1ps
module grid_plot_line_rasterizer_top #(
  parameter int CANVAS_WIDTH  = 800,
  parameter int CANVAS_HEIGHT = 800
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            req_type,
  input  logic signed [gplr_pkg::WORLD_W-1:0]   world_x,
  input  logic signed [gplr_pkg::WORLD_W-1:0]   world_y,
  input  logic [gplr_pkg::READ_W-1:0]           read_col,
  input  logic [gplr_pkg::READ_W-1:0]           read_row,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [gplr_pkg::CFG_W-1:0]            cfg_data,
  output logic                                  done,
  output logic [gplr_pkg::CFG_W-1:0]            pixel_color,
  output logic signed [gplr_pkg::END_ROW_W-1:0] end_row
);

  gplr_pkg::ctrl_cmd_t  cmd;
  gplr_pkg::ctrl_stat_t stat;

  gplr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .cmd      (cmd),
    .stat     (stat)
  );

  gplr_datapath #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .world_x     (world_x),
    .world_y     (world_y),
    .read_col    (read_col),
    .read_row    (read_row),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .pixel_color (pixel_color),
    .end_row     (end_row)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request accepted but busy not raised");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while still busy");
`endif

endmodule

// File: bench/grid_plot_line_rasterizer_top_tb.sv
`timescale 1ns / 1ps
module grid_plot_line_rasterizer_top_tb;

  localparam int W = 800;
  localparam int H = 800;

  typedef struct {
    logic [1:0]         kind;
    logic signed [16:0] wx;
    logic signed [16:0] wy;
    logic [9:0]         col;
    logic [9:0]         row;
  } plot_req_t;

  typedef struct {
    logic [31:0]        color;
    logic signed [11:0] row;
  } plot_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = gplr_pkg::REQ_CLEAR;
  logic signed [gplr_pkg::WORLD_W-1:0] world_x = '0;
  logic signed [gplr_pkg::WORLD_W-1:0] world_y = '0;
  logic [gplr_pkg::READ_W-1:0] read_col = '0;
  logic [gplr_pkg::READ_W-1:0] read_row = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = gplr_pkg::CFG_BACKGROUND;
  logic [gplr_pkg::CFG_W-1:0] cfg_data = '0;
  logic done;
  logic [gplr_pkg::CFG_W-1:0] pixel_color;
  logic signed [gplr_pkg::END_ROW_W-1:0] end_row;

  bit [1:0] canvas_model [0:W*H-1];
  logic [31:0] palette_model [0:3];
  plot_req_t pending_reqs[$];
  plot_rsp_t expected_rsps[$];
  plot_req_t held_req;
  int errors = 0;
  int gap_left = 0;
  int burst_left = 4;

  grid_plot_line_rasterizer_top #(.CANVAS_WIDTH(W), .CANVAS_HEIGHT(H)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .world_x(world_x), .world_y(world_y), .read_col(read_col), .read_row(read_row),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .pixel_color(pixel_color), .end_row(end_row)
  );

  always #10 clk = ~clk;

  function automatic void stamp_square(longint cx, longint cy, bit [1:0] idx);
    for (longint y = cy - 3; y < cy + 3; y++)
      for (longint x = cx - 3; x < cx + 3; x++)
        if (y >= 0 && y < H && x >= 0 && x < W) canvas_model[y*W + x] = idx;
  endfunction

  // Work out the response and apply the request to the canvas model
  function automatic plot_rsp_t rasterize(plot_req_t r);
    plot_rsp_t rsp;
    longint x0, y0, x1, y1, dx, dy, rw;
    bit axis;
    rsp.color = '0;
    rsp.row = '0;
    x0 = W / 2;
    y0 = H / 2;
    x1 = (x0 * 4096 + 40 * longint'(r.wx)) / 4096;
    y1 = (y0 * 4096 - 40 * longint'(r.wy)) / 4096;
    case (r.kind)
      gplr_pkg::REQ_CLEAR: begin
        for (int y = 0; y < H; y++)
          for (int x = 0; x < W; x++) begin
            axis = (y >= y0 - 2 && y <= y0 + 2) || (x >= x0 - 2 && x <= x0 + 2) ||
                   (y % gplr_pkg::GRID_STEP == 0) || (x % gplr_pkg::GRID_STEP == 0);
            canvas_model[y*W + x] = axis ? gplr_pkg::IDX_AXIS : gplr_pkg::IDX_BACKGROUND;
          end
      end
      gplr_pkg::REQ_POINT: stamp_square(x1, y1, gplr_pkg::IDX_POINT);
      gplr_pkg::REQ_VECTOR: begin
        if (x1 >= x0) begin
          dx = x1 - x0;
          dy = y1 - y0;
          for (longint x = x0; x <= x1; x++) begin
            rw = (dx == 0) ? y0 : (y0 * dx + (x - x0) * dy) / dx;
            stamp_square(x, rw, (x1 - x <= gplr_pkg::TIP_COLS) ? gplr_pkg::IDX_TIP
                                                                : gplr_pkg::IDX_POINT);
          end
        end
        rsp.row = y1[11:0];
      end
      default: begin
        if (r.col < W && r.row < H) rsp.color = palette_model[canvas_model[r.row*W + r.col]];
      end
    endcase
    return rsp;
  endfunction

  function automatic plot_req_t mk_req(logic [1:0] k, logic signed [16:0] wx,
                                       logic signed [16:0] wy, int c, int rw);
    plot_req_t r;
    r.kind = k;
    r.wx = wx;
    r.wy = wy;
    r.col = c[9:0];
    r.row = rw[9:0];
    return r;
  endfunction

  function automatic plot_req_t random_req();
    int pick;
    logic signed [16:0] wx, wy;
    pick = $urandom_range(0, 99);
    wx = 17'($urandom);
    wy = 17'($urandom);
    if (pick < 20) return mk_req(gplr_pkg::REQ_POINT, wx, wy, 0, 0);
    if (pick < 30) return mk_req(gplr_pkg::REQ_POINT, 17'($urandom_range(0, 8191) - 4096),
                                 17'($urandom_range(0, 8191) - 4096), 0, 0);
    if (pick < 50) begin
      // keep most vectors short; the divider runs again for every column
      if ($urandom_range(0, 19) == 0) return mk_req(gplr_pkg::REQ_VECTOR, wx, wy, 0, 0);
      if ($urandom_range(0, 5) == 0)
        return mk_req(gplr_pkg::REQ_VECTOR, 17'(-$urandom_range(1, 65536)), wy, 0, 0);
      return mk_req(gplr_pkg::REQ_VECTOR, 17'($urandom_range(0, 2457)), wy, 0, 0);
    end
    if (pick < 75) return mk_req(gplr_pkg::REQ_READ, 0, 0, $urandom_range(380, 460),
                                 $urandom_range(200, 600));
    if (pick < 92) return mk_req(gplr_pkg::REQ_READ, 0, 0, $urandom_range(0, 799),
                                 $urandom_range(0, 799));
    return mk_req(gplr_pkg::REQ_READ, wx, wy, $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
  endfunction

  // Request driver: bursts of back-to-back requests with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_rsps.push_back(rasterize(held_req));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          held_req = pending_reqs.pop_front();
          req_type <= held_req.kind;
          world_x <= held_req.wx;
          world_y <= held_req.wy;
          read_col <= held_req.col;
          read_row <= held_req.row;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual color %h row %0d",
                 $time, pixel_color, end_row);
        errors++;
      end else begin
        plot_rsp_t e;
        e = expected_rsps.pop_front();
        if (pixel_color !== e.color) begin
          $display("%0t: pixel_color mismatch, expected %h, actual %h",
                   $time, e.color, pixel_color);
          errors++;
        end
        if (end_row !== e.row) begin
          $display("%0t: end_row mismatch, expected %0d, actual %0d",
                   $time, e.row, end_row);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || start || busy || expected_rsps.size() > 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_colour(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    palette_model[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    palette_model[0] = gplr_pkg::RST_BACKGROUND;
    palette_model[1] = gplr_pkg::RST_AXIS;
    palette_model[2] = gplr_pkg::RST_POINT;
    palette_model[3] = gplr_pkg::RST_TIP;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset palette, extremes and the odd corners of the drawing rules
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_CLEAR, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 399, 401));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 1, 1));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 799, 799));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 1023, 5));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 5, 800));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_POINT, -17'sd65536, 17'sd65535, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_POINT, 17'sd65535, -17'sd65536, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_POINT, -17'sd40960, 17'sd40960, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_POINT, 17'sd4096, 17'sd4096, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 440, 360));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_VECTOR, 0, 17'sd4096, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_VECTOR, -17'sd1, 17'sd0, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_VECTOR, 17'sd1000, -17'sd3000, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_VECTOR, 17'sd1500, 17'sd65535, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_VECTOR, 17'sd2048, -17'sd65536, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 400, 400));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 410, 396));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_VECTOR, 17'sd65535, 17'sd2000, 0, 0));
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_READ, 0, 0, 799, 380));
    drain();

    write_colour(gplr_pkg::CFG_BACKGROUND, 32'h0000_0000);
    write_colour(gplr_pkg::CFG_AXIS, 32'hFFFF_FFFF);
    write_colour(gplr_pkg::CFG_POINT, 32'h0000_0000);
    write_colour(gplr_pkg::CFG_TIP, 32'hFFFF_FFFF);
    repeat (45) pending_reqs.push_back(random_req());
    drain();

    write_colour(gplr_pkg::CFG_BACKGROUND, $urandom);
    write_colour(gplr_pkg::CFG_AXIS, $urandom);
    write_colour(gplr_pkg::CFG_POINT, $urandom);
    write_colour(gplr_pkg::CFG_TIP, $urandom);
    pending_reqs.push_back(mk_req(gplr_pkg::REQ_CLEAR, 0, 0, 0, 0));
    repeat (45) pending_reqs.push_back(random_req());
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0) $display("grid_plot_line_rasterizer_top_tb: clean");
    else $display("grid_plot_line_rasterizer_top_tb: errors");
    $finish;
  end

  initial begin
    #400ms;
    $display("grid_plot_line_rasterizer_top_tb: errors");
    $finish;
  end

endmodule

// File: grid_plot_line_rasterizer_top.f
rtl/core/gplr_pkg.sv
rtl/core/gplr_ram.sv
rtl/core/gplr_datapath.sv
rtl/core/gplr_ctrl.sv
rtl/core/grid_plot_line_rasterizer_top.sv
bench/grid_plot_line_rasterizer_top_tb.sv
